FILE: rtl/core/fir_lowpass_filter_defines.svh
// Assertion macros shared by the FIR low-pass filter RTL.
`ifndef FIR_LOWPASS_FILTER_DEFINES_SVH
`define FIR_LOWPASS_FILTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define FIR_LP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define FIR_LP_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FIR_LP_ASSERT(label, prop, msg)
`define FIR_LP_NEVER(label, cond, msg)
`endif
`endif

FILE: rtl/core/fir_lp_pkg.sv
// Types, constants and coefficient table of the FIR low-pass filter.
`timescale 1ns / 1ps
`default_nettype none
package fir_lp_pkg;
	localparam int ROM_BITS     = 16;
	localparam int ROM_LEN      = 50;
	localparam int TAP_IDX_BITS = 8;
	localparam int OUT_BITS     = 15;
	localparam int OUT_MIN      = -16384;
	localparam int OUT_MAX      = 16383;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_SCALE
	} fir_state_t;

	// Control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic issue;
		logic live;
	} mac_ctrl_t;

	// Q1.15 coefficients, symmetric about tap 24; taps past the table are zero
	function automatic logic signed [ROM_BITS-1:0] coef_rom(
		input logic [TAP_IDX_BITS-1:0] tap
	);
		logic signed [ROM_BITS-1:0] c;
		case (tap)
			8'd0:  c = 16'sd151;
			8'd1:  c = 16'sd242;
			8'd2:  c = -16'sd79;
			8'd3:  c = -16'sd233;
			8'd4:  c = 16'sd108;
			8'd5:  c = 16'sd3;
			8'd6:  c = -16'sd308;
			8'd7:  c = 16'sd131;
			8'd8:  c = 16'sd144;
			8'd9:  c = -16'sd436;
			8'd10: c = 16'sd98;
			8'd11: c = 16'sd374;
			8'd12: c = -16'sd587;
			8'd13: c = -16'sd36;
			8'd14: c = 16'sd731;
			8'd15: c = -16'sd737;
			8'd16: c = -16'sd357;
			8'd17: c = 16'sd1298;
			8'd18: c = -16'sd862;
			8'd19: c = -16'sd1108;
			8'd20: c = 16'sd2464;
			8'd21: c = -16'sd947;
			8'd22: c = -16'sd3945;
			8'd23: c = 16'sd9434;
			8'd24: c = 16'sd20870;
			8'd25: c = 16'sd9434;
			8'd26: c = -16'sd3945;
			8'd27: c = -16'sd947;
			8'd28: c = 16'sd2464;
			8'd29: c = -16'sd1108;
			8'd30: c = -16'sd862;
			8'd31: c = 16'sd1298;
			8'd32: c = -16'sd357;
			8'd33: c = -16'sd737;
			8'd34: c = 16'sd731;
			8'd35: c = -16'sd36;
			8'd36: c = -16'sd587;
			8'd37: c = 16'sd374;
			8'd38: c = 16'sd98;
			8'd39: c = -16'sd436;
			8'd40: c = 16'sd144;
			8'd41: c = 16'sd131;
			8'd42: c = -16'sd308;
			8'd43: c = 16'sd3;
			8'd44: c = 16'sd108;
			8'd45: c = -16'sd233;
			8'd46: c = -16'sd79;
			8'd47: c = 16'sd242;
			8'd48: c = 16'sd151;
			default: c = '0;
		endcase
		return c;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/fir_lp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fir_lp_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 50
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/fir_lp_mac.sv
// Shared multiply-accumulate unit: align, multiply, accumulate.
`timescale 1ns / 1ps
`default_nettype none
module fir_lp_mac #(
	parameter int SAMPLE_BITS = 13,
	parameter int COEF_BITS   = 16,
	parameter int ACC_BITS    = 36
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fir_lp_pkg::mac_ctrl_t         ctrl,
	input  wire logic signed [COEF_BITS-1:0]   coef,
	input  wire logic signed [SAMPLE_BITS-1:0] rdata,
	output logic signed [ACC_BITS-1:0]         acc,
	output logic                               busy
);
	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;

	logic                        v_s1, v_s2;
	logic                        live_s1;
	logic signed [COEF_BITS-1:0] coef_s1;
	logic signed [PROD_BITS-1:0] prod_s2;
	logic signed [ACC_BITS-1:0]  acc_q;

	// Advance the valid flags of the two stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
		end
	end

	// Hold the coefficient until the RAM data arrives, then multiply
	always_ff @(posedge clk) begin
		coef_s1 <= coef;
		live_s1 <= ctrl.live;
		if (live_s1) begin
			prod_s2 <= PROD_BITS'(rdata) * PROD_BITS'(coef_s1);
		end else begin
			prod_s2 <= '0;
		end
	end

	// Clear on a new request, add each product as it lands
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_BITS'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign busy = v_s1 | v_s2;
endmodule
`default_nettype wire

FILE: rtl/core/fir_lowpass_filter.sv
// Top level of the FIR low-pass filter: sequencer, delay line and output register.
//
// channel   dir  handshake                       payload
// sample    in   sample_valid / sample_stall     sample   [SAMPLE_BITS-1:0] signed
// filtered  out  filtered_valid / filtered_stall filtered [14:0] signed
//
// A request writes the delay line, issues the reads for all TAPS taps through
// the single multiplier, drains its pipeline, and then scales and saturates
// into the output register.
// Reset clears the sequencer, the write pointer and one valid bit per delay-line
// entry; an entry never written reads as zero.
// A result waiting under filtered_stall does not block the next request; only
// the final scale step waits for the output register to free up.
`timescale 1ns / 1ps
`default_nettype none
`include "fir_lowpass_filter_defines.svh"
module fir_lowpass_filter #(
	parameter int TAPS        = 50,
	parameter int SAMPLE_BITS = 13,
	parameter int COEF_BITS   = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  sample_valid,
	output logic                                       sample_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]         sample,
	output logic                                       filtered_valid,
	input  wire logic                                  filtered_stall,
	output logic signed [fir_lp_pkg::OUT_BITS-1:0]     filtered
);
	localparam int TAP_W    = $clog2(TAPS);
	localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + $clog2(TAPS) + 1;
	localparam int ROM_W    = (COEF_BITS > fir_lp_pkg::ROM_BITS) ?
		COEF_BITS : fir_lp_pkg::ROM_BITS;
	localparam int SHL      = (COEF_BITS >= fir_lp_pkg::ROM_BITS) ?
		COEF_BITS - fir_lp_pkg::ROM_BITS : 0;
	localparam int SHR      = (COEF_BITS < fir_lp_pkg::ROM_BITS) ?
		fir_lp_pkg::ROM_BITS - COEF_BITS : 0;
	localparam int QSH      = COEF_BITS - 1;

	fir_lp_pkg::fir_state_t state_q, state_d;
	fir_lp_pkg::mac_ctrl_t  mac_ctrl;

	logic [TAP_W-1:0]                      wr_pos_q, rd_ptr_q, issue_cnt_q;
	logic [TAPS-1:0]                       live_q;
	logic                                  accept, last_issue, scale_load, mac_busy;
	logic signed [SAMPLE_BITS-1:0]         ram_rdata;
	logic signed [fir_lp_pkg::ROM_BITS-1:0] rom_val;
	logic signed [ROM_W-1:0]               rom_ext, rom_adj;
	logic signed [COEF_BITS-1:0]           coef;
	logic signed [ACC_BITS-1:0]            acc, acc_adj, quot;
	logic signed [fir_lp_pkg::OUT_BITS-1:0] sat;
	logic                                  filtered_valid_q;
	logic signed [fir_lp_pkg::OUT_BITS-1:0] filtered_q;

	assign accept     = sample_valid && !sample_stall;
	assign last_issue = (issue_cnt_q == TAP_W'(TAPS - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fir_lp_pkg::ST_IDLE: begin
				if (sample_valid) begin
					state_d = fir_lp_pkg::ST_RUN;
				end
			end
			fir_lp_pkg::ST_RUN: begin
				if (last_issue) begin
					state_d = fir_lp_pkg::ST_DRAIN;
				end
			end
			fir_lp_pkg::ST_DRAIN: begin
				if (!mac_busy) begin
					state_d = fir_lp_pkg::ST_SCALE;
				end
			end
			fir_lp_pkg::ST_SCALE: begin
				if (!filtered_valid_q || !filtered_stall) begin
					state_d = fir_lp_pkg::ST_IDLE;
				end
			end
			default: state_d = fir_lp_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		sample_stall   = 1'b1;
		mac_ctrl.clear = 1'b0;
		mac_ctrl.issue = 1'b0;
		mac_ctrl.live  = 1'b0;
		scale_load     = 1'b0;
		case (state_q)
			fir_lp_pkg::ST_IDLE: begin
				sample_stall   = 1'b0;
				mac_ctrl.clear = sample_valid;
			end
			fir_lp_pkg::ST_RUN: begin
				mac_ctrl.issue = 1'b1;
				mac_ctrl.live  = live_q[rd_ptr_q];
			end
			fir_lp_pkg::ST_DRAIN: begin
				mac_ctrl.issue = 1'b0;
			end
			fir_lp_pkg::ST_SCALE: begin
				scale_load = !filtered_valid_q || !filtered_stall;
			end
			default: sample_stall = 1'b1;
		endcase
	end

	// State, pointers and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fir_lp_pkg::ST_IDLE;
			wr_pos_q    <= '0;
			rd_ptr_q    <= '0;
			issue_cnt_q <= '0;
			live_q      <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				live_q[wr_pos_q] <= 1'b1;
				rd_ptr_q         <= wr_pos_q;
				issue_cnt_q      <= '0;
				wr_pos_q         <= (wr_pos_q == TAP_W'(TAPS - 1)) ? '0 : wr_pos_q + 1'b1;
			end else if (state_q == fir_lp_pkg::ST_RUN) begin
				issue_cnt_q <= issue_cnt_q + 1'b1;
				rd_ptr_q    <= (rd_ptr_q == '0) ? TAP_W'(TAPS - 1) : rd_ptr_q - 1'b1;
			end
		end
	end

	fir_lp_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(TAPS)
	) u_delay (
		.clk  (clk),
		.we   (accept),
		.waddr(wr_pos_q),
		.wdata(sample),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	// Scale the Q1.15 table entry to the coefficient width, truncating toward zero
	always_comb begin
		rom_val = fir_lp_pkg::coef_rom(fir_lp_pkg::TAP_IDX_BITS'(issue_cnt_q));
		rom_ext = ROM_W'(rom_val);
		rom_adj = rom_ext + (rom_ext[ROM_W-1] ? ROM_W'((1 << SHR) - 1) : ROM_W'(0));
		if (COEF_BITS >= fir_lp_pkg::ROM_BITS) begin
			coef = COEF_BITS'(rom_ext <<< SHL);
		end else begin
			coef = COEF_BITS'(rom_adj >>> SHR);
		end
	end

	fir_lp_mac #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS),
		.ACC_BITS   (ACC_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mac_ctrl),
		.coef  (coef),
		.rdata (ram_rdata),
		.acc   (acc),
		.busy  (mac_busy)
	);

	// Drop the fraction toward zero, then clamp to the output range
	always_comb begin
		acc_adj = acc + (acc[ACC_BITS-1] ? ACC_BITS'((1 << QSH) - 1) : ACC_BITS'(0));
		quot    = acc_adj >>> QSH;
		if (quot < ACC_BITS'(fir_lp_pkg::OUT_MIN)) begin
			sat = fir_lp_pkg::OUT_BITS'(fir_lp_pkg::OUT_MIN);
		end else if (quot > ACC_BITS'(fir_lp_pkg::OUT_MAX)) begin
			sat = fir_lp_pkg::OUT_BITS'(fir_lp_pkg::OUT_MAX);
		end else begin
			sat = fir_lp_pkg::OUT_BITS'(quot);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filtered_valid_q <= 1'b0;
		end else if (scale_load) begin
			filtered_valid_q <= 1'b1;
		end else if (!filtered_stall) begin
			filtered_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scale_load) begin
			filtered_q <= sat;
		end
	end

	assign filtered_valid = filtered_valid_q;
	assign filtered       = filtered_q;

	`FIR_LP_ASSERT(a_accept_then_busy, accept |=> sample_stall, "no stall after a request was taken")
	`FIR_LP_NEVER(a_no_overwrite, scale_load && filtered_valid_q && filtered_stall, "result overwritten")
	`FIR_LP_ASSERT(a_idle_mac_quiet, (state_q == fir_lp_pkg::ST_IDLE) |-> !mac_busy, "MAC busy in idle")
	`FIR_LP_ASSERT(a_scale_after_drain, (state_q == fir_lp_pkg::ST_SCALE) |-> !mac_busy, "scale before drain")
	`FIR_LP_ASSERT(a_issue_range, (state_q == fir_lp_pkg::ST_RUN) |-> (issue_cnt_q <= TAP_W'(TAPS - 1)), "tap count out of range")
endmodule
`default_nettype wire
